// ----- hw/rtl/ansi_escape_sequence_classifier_unit_assert.svh -----
`ifndef ANSI_ESCAPE_SEQUENCE_CLASSIFIER_UNIT_ASSERT_SVH
`define ANSI_ESCAPE_SEQUENCE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AESC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define AESC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/aesc_pkg.sv -----
package aesc_pkg;

   localparam int AESC_FIFO_DEPTH = 4;

   localparam logic [7:0] CH_BEL      = 8'h07;
   localparam logic [7:0] CH_CTRLO    = 8'h0F;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_0        = 8'h30;
   localparam logic [7:0] CH_1        = 8'h31;
   localparam logic [7:0] CH_2        = 8'h32;
   localparam logic [7:0] CH_4        = 8'h34;
   localparam logic [7:0] CH_7        = 8'h37;
   localparam logic [7:0] CH_9        = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_QUEST    = 8'h3F;
   localparam logic [7:0] CH_AT       = 8'h40;
   localparam logic [7:0] CH_UPPER_H  = 8'h48;
   localparam logic [7:0] CH_UPPER_J  = 8'h4A;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LOWER_H  = 8'h68;
   localparam logic [7:0] CH_LOWER_L  = 8'h6C;

   localparam logic [2:0] KIND_TEXT  = 3'd0;
   localparam logic [2:0] KIND_CTRLO = 3'd1;
   localparam logic [2:0] KIND_CSI   = 3'd2;
   localparam logic [2:0] KIND_OSC   = 3'd3;
   localparam logic [2:0] KIND_ESC   = 3'd4;
   localparam logic [2:0] KIND_PRIV  = 3'd5;

   localparam logic CSR_STRIP_ANSI  = 1'b0;
   localparam logic CSR_STRIP_TITLE = 1'b1;

   // private-mode match positions: none, 4, 47, 1, 10, 104, 1049, 1047
   localparam logic [2:0] POS_NONE = 3'd0;
   localparam logic [2:0] POS_4    = 3'd1;
   localparam logic [2:0] POS_47   = 3'd2;
   localparam logic [2:0] POS_1    = 3'd3;
   localparam logic [2:0] POS_10   = 3'd4;
   localparam logic [2:0] POS_104  = 3'd5;
   localparam logic [2:0] POS_1049 = 3'd6;
   localparam logic [2:0] POS_1047 = 3'd7;

   localparam logic [3:0] PREFIX_DIGIT [8] = '{4'd0, 4'd4, 4'd7, 4'd1,
                                               4'd0, 4'd4, 4'd9, 4'd7};

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_ESC       = 4'd1,
      PH_CSI_START = 4'd2,
      PH_CSI_PRIV  = 4'd3,
      PH_CSI_BODY  = 4'd4,
      PH_OSC_START = 4'd5,
      PH_OSC_TITLE = 4'd6,
      PH_OSC_OTHER = 4'd7,
      PH_GEN       = 4'd8
   } aesc_phase_type;

   typedef struct packed {
      logic strip_ansi;
      logic strip_title;
   } aesc_cfg_type;

   typedef struct packed {
      logic [2:0] seq_kind;
      logic       strip;
      logic       redraw_req;
      logic       home_req;
      logic       alt_screen;
      logic [7:0] text_byte;
      logic       last;
   } aesc_result_type;

   typedef struct packed {
      logic [1:0]      count;
      aesc_result_type first;
      aesc_result_type second;
   } aesc_step_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] pos;
   } aesc_priv_type;

   function automatic aesc_priv_type priv_next(input logic [2:0] pos, input logic [7:0] b);
      aesc_priv_type r;
      r.hit = 1'b0;
      r.pos = pos;
      case (pos)
         POS_NONE: begin
            if (b == CH_4) begin
               r.hit = 1'b1;
               r.pos = POS_4;
            end else if (b == CH_1) begin
               r.hit = 1'b1;
               r.pos = POS_1;
            end
         end
         POS_4: begin
            if (b == CH_7) begin
               r.hit = 1'b1;
               r.pos = POS_47;
            end
         end
         POS_1: begin
            if (b == CH_0) begin
               r.hit = 1'b1;
               r.pos = POS_10;
            end
         end
         POS_10: begin
            if (b == CH_4) begin
               r.hit = 1'b1;
               r.pos = POS_104;
            end
         end
         POS_104: begin
            if (b == CH_9) begin
               r.hit = 1'b1;
               r.pos = POS_1049;
            end else if (b == CH_7) begin
               r.hit = 1'b1;
               r.pos = POS_1047;
            end
         end
         default: begin
            r.hit = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/aesc_req_if.sv -----
interface aesc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/aesc_rsp_if.sv -----
interface aesc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] seq_kind;
   logic       strip;
   logic       redraw_req;
   logic       home_req;
   logic       alt_screen;
   logic [7:0] text_byte;
   logic       last;

   modport source (output valid, output seq_kind, output strip, output redraw_req,
                   output home_req, output alt_screen, output text_byte, output last,
                   input ready);
   modport sink (input valid, input seq_kind, input strip, input redraw_req,
                 input home_req, input alt_screen, input text_byte, input last,
                 output ready);
endinterface

// ----- hw/rtl/ansi_escape_sequence_classifier_unit.sv -----
// Classifies a terminal byte stream, one byte per req item, into text, Ctrl-O, CSI, OSC,
// other-escape and private-mode results on rsp, each with strip, redraw, cursor-home and
// alternate-screen flags; last marks the final result of a byte. Each byte taken gives zero,
// one or two results, which are written straight into a FIFO_DEPTH-entry result queue;
// req.ready stays high while the queue has at least two free entries, so bytes flow at one per cycle,
// and the single-result-per-cycle rsp port sets the pace when bytes that close one sequence
// and open another (two results) come close together. Results are registered in the queue
// and shown on rsp from its head. strip_ansi sits at address 0 and strip_title at address 4
// of the csr port; write them only while the block is idle.
`include "ansi_escape_sequence_classifier_unit_assert.svh"

module ansi_escape_sequence_classifier_unit #(
   parameter int FIFO_DEPTH = aesc_pkg::AESC_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   aesc_req_if.sink    req,
   aesc_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import aesc_pkg::*;

   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic            strip_ansi_ff;
   logic            strip_title_ff;
   aesc_cfg_type    cfg;
   aesc_step_type   step;
   aesc_result_type fifo_ff [FIFO_DEPTH];
   aesc_result_type head;
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            req_fire;
   logic            rsp_fire;
   logic [1:0]      push_cnt;
   logic            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_STRIP_TITLE) ? {31'd0, strip_title_ff}
                                                         : {31'd0, strip_ansi_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ansi_ff  <= 1'b0;
         strip_title_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_STRIP_ANSI) begin
            strip_ansi_ff <= csr_pwdata[0];
         end else begin
            strip_title_ff <= csr_pwdata[0];
         end
      end
   end

   assign cfg.strip_ansi  = strip_ansi_ff;
   assign cfg.strip_title = strip_title_ff;

   assign req.ready = (count_ff <= CW'(FIFO_DEPTH - 2));
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign push_cnt  = req_fire ? step.count : 2'd0;

   aesc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .in_byte (req.in_byte),
      .cfg     (cfg),
      .step    (step)
   );

   assign wr_ptr_in = wr_ptr_ff + PW'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PW'(rsp_fire);
   assign count_in  = count_ff + CW'(push_cnt) - CW'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= step.first;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + PW'(1)] <= step.second;
      end
   end

   assign head           = fifo_ff[rd_ptr_ff];
   assign rsp.valid      = (count_ff != '0);
   assign rsp.seq_kind   = head.seq_kind;
   assign rsp.strip      = head.strip;
   assign rsp.redraw_req = head.redraw_req;
   assign rsp.home_req   = head.home_req;
   assign rsp.alt_screen = head.alt_screen;
   assign rsp.text_byte  = head.text_byte;
   assign rsp.last       = head.last;

   `AESC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(FIFO_DEPTH),
      "result queue over full")
   `AESC_ASSERT_NEXT(a_double_push, !reset && req_fire && step.count == 2'd2 && !rsp_fire,
      count_ff == $past(count_ff) + CW'(2), "two results of one item not both queued")
   `AESC_ASSERT_NEXT(a_silent_item, !reset && req_fire && step.count == 2'd0 && count_ff == '0,
      !rsp.valid, "result shown for an item that gives none")
   `AESC_ASSERT_NOW(a_pair_last, req_fire && step.count == 2'd2,
      !step.first.last && step.second.last, "last flag wrong on a result pair")

endmodule

// ----- hw/rtl/aesc_parser.sv -----
module aesc_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  aesc_pkg::aesc_cfg_type cfg,
   output aesc_pkg::aesc_step_type step
);
   import aesc_pkg::*;

   aesc_phase_type phase_ff, phase_in;
   logic [2:0]     pos_ff, pos_in;
   logic [3:0]     digit_ff, digit_in;
   logic           end_pending_ff, end_pending_in;
   logic           pend_strip_ff, pend_strip_in;
   logic           pend_redraw_ff, pend_redraw_in;
   logic           pend_home_ff, pend_home_in;
   logic           alt_ff, alt_in;

   logic            fin_valid;
   logic [2:0]      fin_kind;
   logic            fin_strip;
   logic            do_idle;
   logic            do_body;
   logic            do_gen;
   logic            do_osc;
   logic [3:0]      body_digit;
   logic            idle_emit;
   aesc_result_type fin_res;
   aesc_result_type idle_res;
   aesc_priv_type   priv;

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      digit_in       = digit_ff;
      end_pending_in = end_pending_ff;
      pend_strip_in  = pend_strip_ff;
      pend_redraw_in = pend_redraw_ff;
      pend_home_in   = pend_home_ff;
      alt_in         = alt_ff;
      fin_valid      = 1'b0;
      fin_kind       = KIND_TEXT;
      fin_strip      = 1'b0;
      do_idle        = 1'b0;
      do_body        = 1'b0;
      do_gen         = 1'b0;
      do_osc         = 1'b0;
      body_digit     = digit_ff;
      idle_emit      = 1'b0;
      priv           = priv_next(pos_ff, in_byte);
      fin_res        = '0;
      idle_res       = '0;

      if (end_pending_ff) begin
         if (in_byte == CH_SEMI) begin
            end_pending_in = 1'b0;
         end else begin
            fin_valid = 1'b1;
            fin_kind  = (phase_ff == PH_GEN) ? KIND_ESC : KIND_CSI;
            fin_strip = pend_strip_ff;
            do_idle   = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_ESC: begin
               if (in_byte == CH_LBRACKET) begin
                  phase_in = PH_CSI_START;
               end else if (in_byte == CH_RBRACKET) begin
                  phase_in = PH_OSC_START;
               end else begin
                  do_gen = 1'b1;
               end
            end
            PH_CSI_START: begin
               if (in_byte == CH_QUEST) begin
                  phase_in = PH_CSI_PRIV;
                  pos_in   = POS_NONE;
               end else begin
                  do_body = 1'b1;
               end
            end
            PH_CSI_PRIV: begin
               if (priv.hit) begin
                  pos_in = priv.pos;
               end else if ((pos_ff == POS_47 || pos_ff == POS_1049 || pos_ff == POS_1047) &&
                            (in_byte == CH_LOWER_H || in_byte == CH_LOWER_L)) begin
                  alt_in = (in_byte == CH_LOWER_H);
                  if (in_byte == CH_LOWER_L) begin
                     pend_redraw_in = 1'b1;
                  end
                  fin_valid = 1'b1;
                  fin_kind  = KIND_PRIV;
               end else begin
                  body_digit = PREFIX_DIGIT[pos_ff];
                  pos_in     = POS_NONE;
                  do_body    = 1'b1;
               end
            end
            PH_CSI_BODY: begin
               do_body = 1'b1;
            end
            PH_OSC_START: begin
               if (in_byte inside {[CH_0:CH_2]}) begin
                  phase_in = PH_OSC_TITLE;
               end else begin
                  do_osc = 1'b1;
               end
            end
            PH_OSC_TITLE: begin
               if (in_byte == CH_BEL) begin
                  fin_valid = 1'b1;
                  fin_kind  = KIND_OSC;
                  fin_strip = cfg.strip_title | cfg.strip_ansi;
               end
            end
            PH_OSC_OTHER: begin
               do_osc = 1'b1;
            end
            PH_GEN: begin
               do_gen = 1'b1;
            end
            PH_IDLE: begin
               do_idle = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
               do_idle  = 1'b1;
            end
         endcase
      end

      if (do_gen) begin
         phase_in = PH_GEN;
         if (in_byte inside {[CH_0:CH_9], CH_SEMI}) begin
            phase_in = PH_GEN;
         end else if (in_byte == CH_UPPER_H || in_byte == CH_AT) begin
            end_pending_in = 1'b1;
            pend_strip_in  = 1'b0;
         end else begin
            fin_valid = 1'b1;
            fin_kind  = KIND_ESC;
            fin_strip = cfg.strip_ansi;
         end
      end

      if (do_osc) begin
         phase_in = PH_OSC_OTHER;
         if (in_byte == CH_BEL || in_byte == CH_ESC) begin
            fin_valid = 1'b1;
            fin_kind  = KIND_OSC;
            fin_strip = cfg.strip_ansi;
            do_idle   = (in_byte == CH_ESC);
         end
      end

      if (do_body) begin
         phase_in = PH_CSI_BODY;
         digit_in = body_digit;
         if (in_byte inside {[CH_0:CH_9]}) begin
            digit_in = in_byte[3:0];
         end else if (in_byte == CH_SEMI) begin
            digit_in = body_digit;
         end else if (in_byte == CH_UPPER_H) begin
            pend_home_in   = 1'b1;
            pend_redraw_in = 1'b1;
            end_pending_in = 1'b1;
            pend_strip_in  = cfg.strip_ansi;
         end else if (in_byte == CH_UPPER_J) begin
            if (body_digit <= 4'd1) begin
               pend_redraw_in = 1'b1;
            end
            if (body_digit == 4'd2) begin
               pend_home_in   = 1'b1;
               pend_redraw_in = 1'b1;
            end
            end_pending_in = 1'b1;
            pend_strip_in  = cfg.strip_ansi;
         end else if (in_byte == CH_ESC || in_byte == CH_CTRLO) begin
            fin_valid = 1'b1;
            fin_kind  = KIND_CSI;
            fin_strip = 1'b0;
            do_idle   = 1'b1;
         end else begin
            end_pending_in = 1'b1;
            pend_strip_in  = cfg.strip_ansi;
         end
      end

      if (fin_valid) begin
         fin_res.seq_kind   = fin_kind;
         fin_res.strip      = fin_strip;
         fin_res.redraw_req = pend_redraw_in;
         fin_res.home_req   = pend_home_in;
         fin_res.alt_screen = alt_in;
         phase_in       = PH_IDLE;
         pos_in         = POS_NONE;
         digit_in       = 4'd0;
         end_pending_in = 1'b0;
         pend_strip_in  = 1'b0;
         pend_redraw_in = 1'b0;
         pend_home_in   = 1'b0;
      end

      if (do_idle) begin
         idle_res.alt_screen = alt_in;
         if (in_byte == CH_CTRLO) begin
            idle_emit         = 1'b1;
            idle_res.seq_kind = KIND_CTRLO;
            idle_res.strip    = cfg.strip_ansi;
         end else if (in_byte == CH_ESC) begin
            phase_in       = PH_ESC;
            pos_in         = POS_NONE;
            digit_in       = 4'd0;
            end_pending_in = 1'b0;
            pend_strip_in  = 1'b0;
            pend_redraw_in = 1'b0;
            pend_home_in   = 1'b0;
         end else begin
            idle_emit          = 1'b1;
            idle_res.seq_kind  = KIND_TEXT;
            idle_res.text_byte = in_byte;
         end
      end

      step.count  = {1'b0, fin_valid} + {1'b0, idle_emit};
      step.first  = fin_valid ? fin_res : idle_res;
      step.second = idle_res;
      step.first.last  = !(fin_valid && idle_emit);
      step.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pos_ff         <= POS_NONE;
         digit_ff       <= 4'd0;
         end_pending_ff <= 1'b0;
         pend_strip_ff  <= 1'b0;
         pend_redraw_ff <= 1'b0;
         pend_home_ff   <= 1'b0;
         alt_ff         <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         digit_ff       <= digit_in;
         end_pending_ff <= end_pending_in;
         pend_strip_ff  <= pend_strip_in;
         pend_redraw_ff <= pend_redraw_in;
         pend_home_ff   <= pend_home_in;
         alt_ff         <= alt_in;
      end
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import aesc_pkg::*;

   typedef struct packed {
      logic [7:0]      in_byte;
      logic            typed;
      aesc_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   aesc_req_if req_if ();
   aesc_rsp_if rsp_if ();

   ansi_escape_sequence_classifier_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // parser shadow state
   logic           cfg_ansi;
   logic           cfg_title;
   aesc_phase_type phase;
   logic [2:0]     match_pos;
   logic [3:0]     digit;
   logic           end_wait;
   logic           hold_strip;
   logic           hold_redraw;
   logic           hold_home;
   logic           alt_mode;

   aesc_result_type byte_results[$];
   aesc_result_type due_results[$];
   logic [7:0]      seq_bytes[$];
   stim_row_type    dir_rows[28];

   int   fail_count;
   logic idle_on;

   function automatic void post(input logic [2:0] kind, input logic strip,
                                input logic redraw, input logic home,
                                input logic [7:0] text);
      aesc_result_type r;
      r.seq_kind   = kind;
      r.strip      = strip;
      r.redraw_req = redraw;
      r.home_req   = home;
      r.alt_screen = alt_mode;
      r.text_byte  = text;
      r.last       = 1'b0;
      byte_results.push_back(r);
   endfunction

   function automatic void clear_seq();
      match_pos   = POS_NONE;
      digit       = 4'd0;
      end_wait    = 1'b0;
      hold_strip  = 1'b0;
      hold_redraw = 1'b0;
      hold_home   = 1'b0;
   endfunction

   function automatic void close_seq(input logic [2:0] kind, input logic strip);
      post(kind, strip, hold_redraw, hold_home, 8'h00);
      phase = PH_IDLE;
      clear_seq();
   endfunction

   function automatic void plain_byte(input logic [7:0] b);
      if (b == CH_CTRLO) begin
         post(KIND_CTRLO, cfg_ansi, 1'b0, 1'b0, 8'h00);
      end else if (b == CH_ESC) begin
         clear_seq();
         phase = PH_ESC;
      end else begin
         post(KIND_TEXT, 1'b0, 1'b0, 1'b0, b);
      end
   endfunction

   function automatic void hold_end(input logic strip);
      end_wait   = 1'b1;
      hold_strip = strip;
   endfunction

   function automatic void csi_byte(input logic [7:0] b);
      phase = PH_CSI_BODY;
      if (b >= CH_0 && b <= CH_9) begin
         digit = b[3:0];
      end else if (b == CH_SEMI) begin
      end else if (b == CH_UPPER_H) begin
         hold_home   = 1'b1;
         hold_redraw = 1'b1;
         hold_end(cfg_ansi);
      end else if (b == CH_UPPER_J) begin
         if (digit <= 4'd1) hold_redraw = 1'b1;
         if (digit == 4'd2) begin
            hold_home   = 1'b1;
            hold_redraw = 1'b1;
         end
         hold_end(cfg_ansi);
      end else if (b == CH_ESC || b == CH_CTRLO) begin
         close_seq(KIND_CSI, 1'b0);
         plain_byte(b);
      end else begin
         hold_end(cfg_ansi);
      end
   endfunction

   function automatic void esc_body(input logic [7:0] b);
      phase = PH_GEN;
      if ((b >= CH_0 && b <= CH_9) || b == CH_SEMI) begin
      end else if (b == CH_UPPER_H || b == CH_AT) begin
         hold_end(1'b0);
      end else begin
         close_seq(KIND_ESC, cfg_ansi);
      end
   endfunction

   function automatic void osc_body(input logic [7:0] b);
      phase = PH_OSC_OTHER;
      if (b == CH_BEL) begin
         close_seq(KIND_OSC, cfg_ansi);
      end else if (b == CH_ESC) begin
         close_seq(KIND_OSC, cfg_ansi);
         plain_byte(b);
      end
   endfunction

   function automatic void classify_byte(input logic [7:0] b);
      logic       hit;
      logic [2:0] nxt;
      byte_results.delete();
      if (end_wait) begin
         if (b == CH_SEMI) begin
            end_wait = 1'b0;
         end else begin
            close_seq((phase == PH_GEN) ? KIND_ESC : KIND_CSI, hold_strip);
            plain_byte(b);
         end
      end else begin
         case (phase)
            PH_ESC: begin
               if (b == CH_LBRACKET) phase = PH_CSI_START;
               else if (b == CH_RBRACKET) phase = PH_OSC_START;
               else esc_body(b);
            end
            PH_CSI_START: begin
               if (b == CH_QUEST) begin
                  phase     = PH_CSI_PRIV;
                  match_pos = POS_NONE;
               end else begin
                  csi_byte(b);
               end
            end
            PH_CSI_PRIV: begin
               hit = 1'b1;
               nxt = match_pos;
               case (match_pos)
                  POS_NONE: begin
                     if (b == CH_4) nxt = POS_4;
                     else if (b == CH_1) nxt = POS_1;
                     else hit = 1'b0;
                  end
                  POS_4: begin
                     if (b == CH_7) nxt = POS_47;
                     else hit = 1'b0;
                  end
                  POS_1: begin
                     if (b == CH_0) nxt = POS_10;
                     else hit = 1'b0;
                  end
                  POS_10: begin
                     if (b == CH_4) nxt = POS_104;
                     else hit = 1'b0;
                  end
                  POS_104: begin
                     if (b == CH_9) nxt = POS_1049;
                     else if (b == CH_7) nxt = POS_1047;
                     else hit = 1'b0;
                  end
                  default: begin
                     hit = 1'b0;
                  end
               endcase
               if (hit) begin
                  match_pos = nxt;
               end else if ((match_pos == POS_47 || match_pos == POS_1049 ||
                             match_pos == POS_1047) &&
                            (b == CH_LOWER_H || b == CH_LOWER_L)) begin
                  if (b == CH_LOWER_H) begin
                     alt_mode = 1'b1;
                  end else begin
                     alt_mode    = 1'b0;
                     hold_redraw = 1'b1;
                  end
                  close_seq(KIND_PRIV, 1'b0);
               end else begin
                  digit     = PREFIX_DIGIT[match_pos];
                  match_pos = POS_NONE;
                  csi_byte(b);
               end
            end
            PH_CSI_BODY: csi_byte(b);
            PH_OSC_START: begin
               if (b >= CH_0 && b <= CH_2) phase = PH_OSC_TITLE;
               else osc_body(b);
            end
            PH_OSC_TITLE: begin
               if (b == CH_BEL) close_seq(KIND_OSC, cfg_title | cfg_ansi);
            end
            PH_OSC_OTHER: osc_body(b);
            PH_GEN: esc_body(b);
            default: begin
               phase = PH_IDLE;
               plain_byte(b);
            end
         endcase
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[i]) due_results.push_back(byte_results[i]);
   endfunction

   function automatic string show_result(input aesc_result_type r);
      return $sformatf("kind=%0d strip=%0b redraw=%0b home=%0b alt=%0b text=%02h last=%0b",
                       r.seq_kind, r.strip, r.redraw_req, r.home_req, r.alt_screen,
                       r.text_byte, r.last);
   endfunction

   function automatic void show_mismatch(input string what, input aesc_result_type want,
                                         input aesc_result_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: expected %s, got %s", what, show_result(want), show_result(got));
   endfunction

   function automatic stim_row_type free_row(input logic [7:0] b);
      stim_row_type r;
      r.in_byte = b;
      r.typed   = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(input logic [7:0] b, input logic [2:0] kind,
                                              input logic strip, input logic redraw,
                                              input logic home, input logic alt,
                                              input logic [7:0] text, input logic last);
      stim_row_type r;
      r.in_byte         = b;
      r.typed           = 1'b1;
      r.want.seq_kind   = kind;
      r.want.strip      = strip;
      r.want.redraw_req = redraw;
      r.want.home_req   = home;
      r.want.alt_screen = alt;
      r.want.text_byte  = text;
      r.want.last       = last;
      return r;
   endfunction

   function automatic void add_params(input int n);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0) seq_bytes.push_back(CH_SEMI);
         else seq_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
      end
   endfunction

   function automatic logic [7:0] csi_end();
      case ($urandom_range(0, 6))
         0: return CH_UPPER_H;
         1: return CH_UPPER_J;
         2: return 8'h6D;
         3: return 8'($urandom_range(64, 126));
         4: return CH_ESC;
         5: return CH_CTRLO;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void build_sequence();
      logic [7:0] b;
      seq_bytes.delete();
      case ($urandom_range(0, 15))
         0, 1: begin
            repeat ($urandom_range(1, 6)) seq_bytes.push_back(8'($urandom_range(32, 126)));
         end
         2: seq_bytes.push_back(CH_CTRLO);
         3, 4, 5, 6: begin
            seq_bytes.push_back(CH_ESC);
            seq_bytes.push_back(CH_LBRACKET);
            add_params($urandom_range(0, 3));
            seq_bytes.push_back(csi_end());
            if ($urandom_range(0, 3) == 0) begin
               seq_bytes.push_back(CH_SEMI);
               add_params($urandom_range(0, 2));
               seq_bytes.push_back(csi_end());
            end
         end
         7, 8, 9: begin
            seq_bytes.push_back(CH_ESC);
            seq_bytes.push_back(CH_LBRACKET);
            seq_bytes.push_back(CH_QUEST);
            case ($urandom_range(0, 6))
               0: begin
                  seq_bytes.push_back(CH_4);
                  seq_bytes.push_back(CH_7);
               end
               1, 2: begin
                  seq_bytes.push_back(CH_1);
                  seq_bytes.push_back(CH_0);
                  seq_bytes.push_back(CH_4);
                  seq_bytes.push_back($urandom_range(0, 1) ? CH_9 : CH_7);
               end
               3: seq_bytes.push_back(CH_4);
               4: seq_bytes.push_back(CH_1);
               5: begin
                  seq_bytes.push_back(CH_1);
                  seq_bytes.push_back(CH_0);
               end
               default: begin
                  seq_bytes.push_back(CH_1);
                  seq_bytes.push_back(CH_0);
                  seq_bytes.push_back(CH_4);
               end
            endcase
            case ($urandom_range(0, 5))
               0, 1: seq_bytes.push_back(CH_LOWER_H);
               2, 3: seq_bytes.push_back(CH_LOWER_L);
               4: seq_bytes.push_back(8'($urandom_range(32, 126)));
               default: seq_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         10: begin
            seq_bytes.push_back(CH_ESC);
            seq_bytes.push_back(CH_RBRACKET);
            seq_bytes.push_back(8'(CH_0 + $urandom_range(0, 2)));
            repeat ($urandom_range(0, 5)) seq_bytes.push_back(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 7) != 0) seq_bytes.push_back(CH_BEL);
         end
         11: begin
            seq_bytes.push_back(CH_ESC);
            seq_bytes.push_back(CH_RBRACKET);
            case ($urandom_range(0, 3))
               0: seq_bytes.push_back(CH_BEL);
               1: seq_bytes.push_back(CH_ESC);
               default: begin
                  seq_bytes.push_back(8'($urandom_range(51, 126)));
                  repeat ($urandom_range(0, 4))
                     seq_bytes.push_back(8'($urandom_range(32, 126)));
                  seq_bytes.push_back($urandom_range(0, 1) ? CH_BEL : CH_ESC);
               end
            endcase
         end
         12, 13, 14: begin
            seq_bytes.push_back(CH_ESC);
            case ($urandom_range(0, 5))
               0: seq_bytes.push_back(8'($urandom_range(32, 126)));
               1: seq_bytes.push_back(CH_UPPER_H);
               2: seq_bytes.push_back(CH_AT);
               3: begin
                  add_params($urandom_range(1, 3));
                  case ($urandom_range(0, 2))
                     0: seq_bytes.push_back(CH_UPPER_H);
                     1: seq_bytes.push_back(CH_AT);
                     default: seq_bytes.push_back(8'($urandom_range(0, 255)));
                  endcase
               end
               4: seq_bytes.push_back(8'($urandom_range(0, 255)));
               default: seq_bytes.push_back(8'h28);
            endcase
            b = seq_bytes[seq_bytes.size() - 1];
            if ((b == CH_UPPER_H || b == CH_AT) && $urandom_range(0, 2) == 0) begin
               seq_bytes.push_back(CH_SEMI);
               add_params($urandom_range(0, 2));
               seq_bytes.push_back(CH_UPPER_H);
            end
         end
         default: begin
            repeat ($urandom_range(1, 8)) seq_bytes.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.in_byte = b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_STRIP_ANSI) cfg_ansi = data[0];
      else cfg_title = data[0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_config(input logic ansi, input logic title);
      write_csr(CSR_STRIP_ANSI, {31'($urandom), ansi});
      write_csr(CSR_STRIP_TITLE, {31'($urandom), title});
   endtask

   task automatic settle();
      req_if.valid = 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      aesc_result_type got;
      aesc_result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.seq_kind   = rsp_if.seq_kind;
            got.strip      = rsp_if.strip;
            got.redraw_req = rsp_if.redraw_req;
            got.home_req   = rsp_if.home_req;
            got.alt_screen = rsp_if.alt_screen;
            got.text_byte  = rsp_if.text_byte;
            got.last       = rsp_if.last;
            if (due_results.size() == 0) begin
               show_mismatch("unexpected item", '0, got);
            end else begin
               want = due_results.pop_front();
               if (got !== want) show_mismatch("item", want, got);
            end
         end
         if (req_if.valid && req_if.ready) classify_byte(req_if.in_byte);
      end
   end

   initial begin
      int sent;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.in_byte = 8'h00;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      fail_count     = 0;
      idle_on        = 1'b0;
      cfg_ansi       = 1'b0;
      cfg_title      = 1'b0;
      phase          = PH_IDLE;
      alt_mode       = 1'b0;
      clear_seq();

      dir_rows = '{
         fixed_row(8'h00, KIND_TEXT, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1),
         fixed_row(8'hFF, KIND_TEXT, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b1),
         fixed_row(CH_CTRLO, KIND_CTRLO, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1),
         free_row(CH_ESC), free_row(CH_LBRACKET), free_row(CH_QUEST),
         free_row(CH_1), free_row(CH_0), free_row(CH_4), free_row(CH_7),
         fixed_row(CH_LOWER_H, KIND_PRIV, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1),
         free_row(CH_ESC), free_row(CH_LBRACKET), free_row(CH_2), free_row(CH_UPPER_J),
         fixed_row(CH_CTRLO, KIND_CSI, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0),
         free_row(CH_ESC), free_row(CH_RBRACKET), free_row(CH_2),
         fixed_row(CH_BEL, KIND_OSC, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1),
         free_row(CH_ESC), free_row(CH_LBRACKET), free_row(CH_QUEST),
         free_row(CH_4), free_row(CH_7),
         fixed_row(CH_LOWER_L, KIND_PRIV, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1),
         free_row(CH_ESC),
         fixed_row(8'h28, KIND_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1)
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_config(1'b0, 1'b0);
      idle_on = 1'b1;
      foreach (dir_rows[i]) begin
         push_byte(dir_rows[i].in_byte);
         if (dir_rows[i].typed) begin
            if (byte_results.size() == 0) show_mismatch("table", dir_rows[i].want, '0);
            else if (byte_results[0] !== dir_rows[i].want)
               show_mismatch("table", dir_rows[i].want, byte_results[0]);
         end
      end
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_config(1'b1, 1'b1);
            1: set_config(1'b1, 1'b0);
            2: set_config(1'b0, 1'b1);
            3: set_config(1'b0, 1'b0);
            default: set_config(1'($urandom), 1'($urandom));
         endcase
         idle_on = (ph < 5);
         sent = 0;
         while (sent < 320) begin
            build_sequence();
            foreach (seq_bytes[i]) push_byte(seq_bytes[i]);
            sent += seq_bytes.size();
         end
         settle();
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0 && due_results.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
